@@ design/bir_pkg.sv @@
package bir_pkg;

   localparam int DEF_MAX_WIDTH    = 128;
   localparam int DEF_MAX_HEIGHT   = 128;
   localparam int DEF_MAX_CHANNELS = 4;

   localparam int COORD_W   = 12;
   localparam int STEP_W    = 24;
   localparam int SAMPLE_W  = 16;
   localparam int CHAN_W    = 2;
   localparam int SIZE_W    = 8;
   localparam int COUNT_W   = 3;
   localparam int PROD_W    = COORD_W + STEP_W;
   localparam int IPART_W   = PROD_W - SAMPLE_W;
   localparam int NUM_BANKS = 4;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;

   localparam logic [CSR_INDEX_W-1:0] CSR_SRC_WIDTH     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SRC_HEIGHT    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHANNEL_COUNT = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_X_STEP        = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_Y_STEP        = 3'd4;

   localparam logic [SIZE_W-1:0]  RST_SRC_WIDTH     = 8'd128;
   localparam logic [SIZE_W-1:0]  RST_SRC_HEIGHT    = 8'd128;
   localparam logic [COUNT_W-1:0] RST_CHANNEL_COUNT = 3'd3;
   localparam logic [STEP_W-1:0]  RST_X_STEP        = 24'd65536;
   localparam logic [STEP_W-1:0]  RST_Y_STEP        = 24'd65536;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   typedef struct packed {
      logic                command;
      logic [COORD_W-1:0]  col;
      logic [COORD_W-1:0]  row;
      logic [CHAN_W-1:0]   chan;
      logic [SAMPLE_W-1:0] sample_in;
   } req_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample_out;
      logic [CHAN_W-1:0]   out_chan;
      logic                last;
   } rsp_type;

   typedef struct packed {
      logic              valid;
      logic [CHAN_W-1:0] chan;
      logic              last;
   } tag_type;

   // (a*(1-f) + b*f), truncated
   function automatic logic [SAMPLE_W-1:0] lerp16(input logic [SAMPLE_W-1:0] a,
                                                  input logic [SAMPLE_W-1:0] b,
                                                  input logic [SAMPLE_W-1:0] f);
      logic [SAMPLE_W:0]     nf;
      logic [2*SAMPLE_W:0]   p0;
      logic [2*SAMPLE_W:0]   p1;
      logic [2*SAMPLE_W+1:0] acc;
      nf  = 17'h10000 - {1'b0, f};
      p0  = 33'(a) * 33'(nf);
      p1  = 33'(b) * 33'(f);
      acc = 34'(p0) + 34'(p1);
      return acc[2*SAMPLE_W-1:SAMPLE_W];
   endfunction

endpackage

@@ design/bilinear_image_resampler.sv @@
// Bilinear image resampler. A write transfer (command 0) stores one source
// sample and leaves busy low. A query transfer (command 1) holds busy high
// until its last result leaves: the coordinate units multiply the
// destination coordinate by the step ratios in ST_PROD, split and clamp it
// in ST_SPLIT, then one channel per cycle reads its four neighbours from
// four column/row parity banks, and a two-stage interpolator finishes
// each channel. The channel_count results leave on consecutive
// cycles, one per rsp_valid strobe, channel 0 first, last set on the final
// one, which appears in the last busy cycle. rsp_valid is a one-cycle strobe
// and the receiver cannot stall it. Write configuration only while busy is
// low and no result is pending. Reads of never-written store locations
// return undefined data.
module bilinear_image_resampler #(
   parameter int MAX_WIDTH    = bir_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT   = bir_pkg::DEF_MAX_HEIGHT,
   parameter int MAX_CHANNELS = bir_pkg::DEF_MAX_CHANNELS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  bir_pkg::req_type                req_data,
   output logic                            rsp_valid,
   output bir_pkg::rsp_type                rsp_data,
   input  logic                            csr_we,
   input  logic [bir_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [bir_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int CW  = $clog2(MAX_WIDTH);
   localparam int RW  = $clog2(MAX_HEIGHT);
   localparam int CHW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int DIM_W = bir_pkg::COORD_W + 1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PROD,
      ST_SPLIT,
      ST_READ,
      ST_DRAIN
   } state_type;

   state_type                         state_ff;
   logic [bir_pkg::COORD_W-1:0]       q_col_ff;
   logic [bir_pkg::COORD_W-1:0]       q_row_ff;
   logic [CHW-1:0]                    chan_ff;
   bir_pkg::tag_type                  rd_tag_ff;

   logic [bir_pkg::SIZE_W-1:0]        src_width_ff;
   logic [bir_pkg::SIZE_W-1:0]        src_height_ff;
   logic [bir_pkg::COUNT_W-1:0]       channel_count_ff;
   logic [bir_pkg::STEP_W-1:0]        x_step_ff;
   logic [bir_pkg::STEP_W-1:0]        y_step_ff;

   logic                              accept;
   logic                              wr_en;
   logic [DIM_W-1:0]                  w_sat;
   logic [DIM_W-1:0]                  h_sat;
   logic [DIM_W-1:0]                  w_last;
   logic [DIM_W-1:0]                  h_last;
   logic [bir_pkg::COUNT_W-1:0]       nc_sat;
   logic [bir_pkg::COUNT_W-1:0]       nc_last;
   logic                              chan_is_last;

   logic [CW-1:0]                     x0;
   logic [CW-1:0]                     x1;
   logic [RW-1:0]                     y0;
   logic [RW-1:0]                     y1;
   logic [bir_pkg::SAMPLE_W-1:0]      fx;
   logic [bir_pkg::SAMPLE_W-1:0]      fy;

   logic                                                 rd_en;
   logic [bir_pkg::NUM_BANKS-1:0][CW-1:0]                rd_col;
   logic [bir_pkg::NUM_BANKS-1:0][RW-1:0]                rd_row;
   logic [bir_pkg::NUM_BANKS-1:0][bir_pkg::SAMPLE_W-1:0] rd_data;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;
   assign wr_en  = accept && (req_data.command == bir_pkg::CMD_WRITE)
                   && ({1'b0, req_data.col} < DIM_W'(MAX_WIDTH))
                   && ({1'b0, req_data.row} < DIM_W'(MAX_HEIGHT))
                   && ({1'b0, req_data.chan} < 3'(MAX_CHANNELS));

   always_comb begin
      if (src_width_ff == '0) begin
         w_sat = DIM_W'(1);
      end else if (DIM_W'(src_width_ff) > DIM_W'(MAX_WIDTH)) begin
         w_sat = DIM_W'(MAX_WIDTH);
      end else begin
         w_sat = DIM_W'(src_width_ff);
      end
      if (src_height_ff == '0) begin
         h_sat = DIM_W'(1);
      end else if (DIM_W'(src_height_ff) > DIM_W'(MAX_HEIGHT)) begin
         h_sat = DIM_W'(MAX_HEIGHT);
      end else begin
         h_sat = DIM_W'(src_height_ff);
      end
      if (channel_count_ff == '0) begin
         nc_sat = 3'd1;
      end else if (channel_count_ff > 3'(MAX_CHANNELS)) begin
         nc_sat = 3'(MAX_CHANNELS);
      end else begin
         nc_sat = channel_count_ff;
      end
      w_last  = w_sat - 1'b1;
      h_last  = h_sat - 1'b1;
      nc_last = nc_sat - 1'b1;
   end

   assign chan_is_last = (3'(chan_ff) == nc_last);

   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff     <= bir_pkg::RST_SRC_WIDTH;
         src_height_ff    <= bir_pkg::RST_SRC_HEIGHT;
         channel_count_ff <= bir_pkg::RST_CHANNEL_COUNT;
         x_step_ff        <= bir_pkg::RST_X_STEP;
         y_step_ff        <= bir_pkg::RST_Y_STEP;
      end else if (csr_we) begin
         unique case (csr_index)
            bir_pkg::CSR_SRC_WIDTH:     src_width_ff     <= csr_wdata[bir_pkg::SIZE_W-1:0];
            bir_pkg::CSR_SRC_HEIGHT:    src_height_ff    <= csr_wdata[bir_pkg::SIZE_W-1:0];
            bir_pkg::CSR_CHANNEL_COUNT: channel_count_ff <= csr_wdata[bir_pkg::COUNT_W-1:0];
            bir_pkg::CSR_X_STEP:        x_step_ff        <= csr_wdata;
            bir_pkg::CSR_Y_STEP:        y_step_ff        <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         chan_ff   <= '0;
         rd_tag_ff <= '0;
      end else begin
         rd_tag_ff.valid <= rd_en;
         rd_tag_ff.chan  <= bir_pkg::CHAN_W'(chan_ff);
         rd_tag_ff.last  <= chan_is_last;
         unique case (state_ff)
            ST_IDLE: begin
               if (accept && (req_data.command == bir_pkg::CMD_QUERY)) begin
                  state_ff <= ST_PROD;
               end
            end
            ST_PROD: begin
               state_ff <= ST_SPLIT;
            end
            ST_SPLIT: begin
               chan_ff  <= '0;
               state_ff <= ST_READ;
            end
            ST_READ: begin
               chan_ff <= chan_ff + 1'b1;
               if (chan_is_last) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               if (rsp_valid && rsp_data.last) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         q_col_ff <= req_data.col;
         q_row_ff <= req_data.row;
      end
   end

   bir_coord #(
      .IDX_W (CW)
   ) u_coord_x (
      .clock      (clock),
      .load_prod  (state_ff == ST_PROD),
      .load_split (state_ff == ST_SPLIT),
      .pos        (q_col_ff),
      .step       (x_step_ff),
      .last_pos   (w_last[CW-1:0]),
      .i0         (x0),
      .i1         (x1),
      .frac       (fx)
   );

   bir_coord #(
      .IDX_W (RW)
   ) u_coord_y (
      .clock      (clock),
      .load_prod  (state_ff == ST_PROD),
      .load_split (state_ff == ST_SPLIT),
      .pos        (q_row_ff),
      .step       (y_step_ff),
      .last_pos   (h_last[RW-1:0]),
      .i0         (y0),
      .i1         (y1),
      .frac       (fy)
   );

   assign rd_en = (state_ff == ST_READ);

   // each bank serves whichever neighbour has its parity
   always_comb begin
      for (int b = 0; b < bir_pkg::NUM_BANKS; b++) begin
         rd_col[b] = (x0[0] == b[0]) ? x0 : x1;
         rd_row[b] = (y0[0] == b[1]) ? y0 : y1;
      end
   end

   bir_store #(
      .MAX_WIDTH    (MAX_WIDTH),
      .MAX_HEIGHT   (MAX_HEIGHT),
      .MAX_CHANNELS (MAX_CHANNELS),
      .CW           (CW),
      .RW           (RW),
      .CHW          (CHW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_col  (req_data.col[CW-1:0]),
      .wr_row  (req_data.row[RW-1:0]),
      .wr_chan (req_data.chan[CHW-1:0]),
      .wr_data (req_data.sample_in),
      .rd_en   (rd_en),
      .rd_col  (rd_col),
      .rd_row  (rd_row),
      .rd_chan (chan_ff),
      .rd_data (rd_data)
   );

   bir_lerp u_lerp (
      .clock     (clock),
      .reset     (reset),
      .tag_in    (rd_tag_ff),
      .v00       (rd_data[{y0[0], x0[0]}]),
      .v10       (rd_data[{y0[0], x1[0]}]),
      .v01       (rd_data[{y1[0], x0[0]}]),
      .v11       (rd_data[{y1[0], x1[0]}]),
      .fx        (fx),
      .fy        (fy),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

@@ design/bir_coord.sv @@
module bir_coord #(
   parameter int IDX_W = 7
) (
   input  logic                          clock,
   input  logic                          load_prod,
   input  logic                          load_split,
   input  logic [bir_pkg::COORD_W-1:0]   pos,
   input  logic [bir_pkg::STEP_W-1:0]    step,
   input  logic [IDX_W-1:0]              last_pos,
   output logic [IDX_W-1:0]              i0,
   output logic [IDX_W-1:0]              i1,
   output logic [bir_pkg::SAMPLE_W-1:0]  frac
);

   logic [bir_pkg::PROD_W-1:0]   prod_ff;
   logic [bir_pkg::IPART_W-1:0]  ipart;
   logic [IDX_W-1:0]             i0_in;
   logic [IDX_W-1:0]             i1_in;
   logic [bir_pkg::SAMPLE_W-1:0] frac_in;
   logic [IDX_W-1:0]             i0_ff;
   logic [IDX_W-1:0]             i1_ff;
   logic [bir_pkg::SAMPLE_W-1:0] frac_ff;

   assign ipart = prod_ff[bir_pkg::PROD_W-1:bir_pkg::SAMPLE_W];

   always_comb begin
      if (ipart > bir_pkg::IPART_W'(last_pos)) begin
         i0_in   = last_pos;
         frac_in = '0;
      end else begin
         i0_in   = ipart[IDX_W-1:0];
         frac_in = prod_ff[bir_pkg::SAMPLE_W-1:0];
      end
      i1_in = (i0_in == last_pos) ? last_pos : i0_in + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (load_prod) begin
         prod_ff <= bir_pkg::PROD_W'(pos) * bir_pkg::PROD_W'(step);
      end
      if (load_split) begin
         i0_ff   <= i0_in;
         i1_ff   <= i1_in;
         frac_ff <= frac_in;
      end
   end

   assign i0   = i0_ff;
   assign i1   = i1_ff;
   assign frac = frac_ff;

endmodule

@@ design/bir_store.sv @@
module bir_store #(
   parameter int MAX_WIDTH    = bir_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT   = bir_pkg::DEF_MAX_HEIGHT,
   parameter int MAX_CHANNELS = bir_pkg::DEF_MAX_CHANNELS,
   parameter int CW           = $clog2(MAX_WIDTH),
   parameter int RW           = $clog2(MAX_HEIGHT),
   parameter int CHW          = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1
) (
   input  logic                                                clock,
   input  logic                                                wr_en,
   input  logic [CW-1:0]                                       wr_col,
   input  logic [RW-1:0]                                       wr_row,
   input  logic [CHW-1:0]                                      wr_chan,
   input  logic [bir_pkg::SAMPLE_W-1:0]                        wr_data,
   input  logic                                                rd_en,
   input  logic [bir_pkg::NUM_BANKS-1:0][CW-1:0]               rd_col,
   input  logic [bir_pkg::NUM_BANKS-1:0][RW-1:0]               rd_row,
   input  logic [CHW-1:0]                                      rd_chan,
   output logic [bir_pkg::NUM_BANKS-1:0][bir_pkg::SAMPLE_W-1:0] rd_data
);

   localparam int HALF_W     = (MAX_WIDTH + 1) / 2;
   localparam int HALF_H     = (MAX_HEIGHT + 1) / 2;
   localparam int BANK_DEPTH = HALF_W * HALF_H * MAX_CHANNELS;
   localparam int BAW        = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

   // banks interleave on column and row parity: bank = {row[0], col[0]}
   function automatic logic [BAW-1:0] bank_addr(input logic [CW-1:0]  c,
                                                input logic [RW-1:0]  r,
                                                input logic [CHW-1:0] ch);
      logic [31:0] lin;
      lin = ((32'(r >> 1) * HALF_W) + 32'(c >> 1)) * MAX_CHANNELS + 32'(ch);
      return lin[BAW-1:0];
   endfunction

   logic [1:0]     wr_bank;
   logic [BAW-1:0] wr_addr;

   assign wr_bank = {wr_row[0], wr_col[0]};
   assign wr_addr = bank_addr(wr_col, wr_row, wr_chan);

   for (genvar b = 0; b < bir_pkg::NUM_BANKS; b++) begin : g_bank
      logic [bir_pkg::SAMPLE_W-1:0] bank_mem_ff [BANK_DEPTH];
      logic [bir_pkg::SAMPLE_W-1:0] rd_q_ff;
      logic [BAW-1:0]               rd_addr;

      assign rd_addr = bank_addr(rd_col[b], rd_row[b], rd_chan);

      always_ff @(posedge clock) begin
         if (wr_en && (wr_bank == 2'(b))) begin
            bank_mem_ff[wr_addr] <= wr_data;
         end
         if (rd_en) begin
            rd_q_ff <= bank_mem_ff[rd_addr];
         end
      end

      assign rd_data[b] = rd_q_ff;
   end

endmodule

@@ design/bir_lerp.sv @@
module bir_lerp (
   input  logic                         clock,
   input  logic                         reset,
   input  bir_pkg::tag_type             tag_in,
   input  logic [bir_pkg::SAMPLE_W-1:0] v00,
   input  logic [bir_pkg::SAMPLE_W-1:0] v10,
   input  logic [bir_pkg::SAMPLE_W-1:0] v01,
   input  logic [bir_pkg::SAMPLE_W-1:0] v11,
   input  logic [bir_pkg::SAMPLE_W-1:0] fx,
   input  logic [bir_pkg::SAMPLE_W-1:0] fy,
   output logic                         rsp_valid,
   output bir_pkg::rsp_type             rsp_data
);

   bir_pkg::tag_type             tag_a_ff;
   logic [bir_pkg::SAMPLE_W-1:0] top_ff;
   logic [bir_pkg::SAMPLE_W-1:0] bot_ff;
   logic                         rsp_valid_ff;
   bir_pkg::rsp_type             rsp_data_ff;

   // horizontal pass
   always_ff @(posedge clock) begin
      if (reset) begin
         tag_a_ff <= '0;
      end else begin
         tag_a_ff <= tag_in;
      end
      top_ff <= bir_pkg::lerp16(v00, v10, fx);
      bot_ff <= bir_pkg::lerp16(v01, v11, fx);
   end

   // vertical pass
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= tag_a_ff.valid;
      end
      rsp_data_ff.sample_out <= bir_pkg::lerp16(top_ff, bot_ff, fy);
      rsp_data_ff.out_chan   <= tag_a_ff.chan;
      rsp_data_ff.last       <= tag_a_ff.last;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ design/bir_checker.sv @@
module bir_sva_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input bir_pkg::req_type req_data,
   input logic             rsp_valid,
   input bir_pkg::rsp_type rsp_data
);

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result strobe after reset");

   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_data.command == bir_pkg::CMD_QUERY) |=> busy)
      else $error("query transfer did not raise busy");

   a_write_free: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_data.command == bir_pkg::CMD_WRITE) |=> !busy)
      else $error("write transfer raised busy");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last |=> !rsp_valid)
      else $error("result right after last");

   a_chan_seq: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last |=>
         rsp_valid && (rsp_data.out_chan == $past(rsp_data.out_chan) + 2'd1))
      else $error("channel results not consecutive");

endmodule

bind bilinear_image_resampler bir_sva_checker u_bir_checker (.*);
